// ===== rtl/rbcs_pkg.sv =====
// Shared types and helper functions for the rotated byte constant splitter.
package rbcs_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned PosWidth   = 6;
    localparam int unsigned PairCount  = WordWidth / 2;
    localparam int unsigned CountWidth = 3;

    typedef logic [WordWidth-1:0]  word_t;
    typedef logic [PosWidth-1:0]   pos_t;
    typedef logic [CountWidth-1:0] count_t;

    localparam count_t CountOne   = 3'd1;
    localparam count_t CountTwo   = 3'd2;
    localparam count_t CountThree = 3'd3;
    localparam count_t CountFour  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic hit1;
        logic skip1;
        logic hit2;
        logic last_k;
    } status_t;

    typedef struct packed {
        logic found;
        pos_t pos;
    } search_t;

    function automatic word_t rot_byte(input pos_t amount);
        logic [2*WordWidth-1:0] wide;
        begin
            wide = {{WordWidth{1'b0}}, word_t'(8'hFF)} << amount[4:0];
            return wide[WordWidth-1:0] | wide[2*WordWidth-1:WordWidth];
        end
    endfunction

    function automatic search_t first_pair(input word_t v, input pos_t from, input pos_t hi);
        search_t res;
        pos_t    p;
        begin
            res = '0;
            for (int i = PairCount - 1; i >= 0; i--)
            begin
                p = pos_t'(2 * i);
                if (p >= from && p < hi && v[2*i +: 2] != 2'b00)
                begin
                    res.found = 1'b1;
                    res.pos   = p;
                end
            end
            return res;
        end
    endfunction

    function automatic pos_t low_pair(input word_t v);
        pos_t lo;
        begin
            lo = pos_t'(WordWidth - 2);
            for (int i = PairCount - 1; i >= 0; i--)
            begin
                if (v[2*i +: 2] != 2'b00)
                    lo = pos_t'(2 * i);
            end
            return lo;
        end
    endfunction

    function automatic pos_t high_bound(input word_t v);
        pos_t hi;
        begin
            hi = pos_t'(2);
            for (int i = 0; i < PairCount; i++)
            begin
                if (v[2*i +: 2] != 2'b00)
                    hi = pos_t'(2 * i + 2);
            end
            return hi;
        end
    endfunction

endpackage

// ===== rtl/rbcs_ctrl.sv =====
// Controller state machine stepping the candidate rotations.
module rbcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rbcs_pkg::status_t status,
    output rbcs_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done
);

    rbcs_pkg::state_t state_reg;
    rbcs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rbcs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbcs_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = rbcs_pkg::ST_FIRST;
            end
            rbcs_pkg::ST_FIRST:
            begin
                if (status.hit1)
                    state_next = rbcs_pkg::ST_FINISH;
                else if (status.skip1)
                    state_next = status.last_k ? rbcs_pkg::ST_FINISH : rbcs_pkg::ST_FIRST;
                else
                    state_next = rbcs_pkg::ST_SECOND;
            end
            rbcs_pkg::ST_SECOND:
            begin
                if (status.hit2 || status.last_k)
                    state_next = rbcs_pkg::ST_FINISH;
                else
                    state_next = rbcs_pkg::ST_FIRST;
            end
            rbcs_pkg::ST_FINISH:
            begin
                state_next = rbcs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rbcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            rbcs_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            rbcs_pkg::ST_FIRST:
            begin
                cmd.step1   = 1'b1;
                cmd.advance = !status.hit1 && status.skip1;
            end
            rbcs_pkg::ST_SECOND:
            begin
                cmd.step2   = 1'b1;
                cmd.advance = !status.hit2;
            end
            rbcs_pkg::ST_FINISH:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/rbcs_datapath.sv =====
// Datapath: candidate masks, greedy pair search and result registers.
module rbcs_datapath (
    input  logic                 clk,
    input  rbcs_pkg::word_t      constant_value,
    input  rbcs_pkg::cmd_t       cmd,
    output rbcs_pkg::status_t    status,
    output rbcs_pkg::count_t     piece_count,
    output rbcs_pkg::word_t      piece_zero,
    output rbcs_pkg::word_t      piece_one,
    output rbcs_pkg::word_t      piece_two,
    output rbcs_pkg::word_t      piece_three
);

    rbcs_pkg::word_t  c_reg;
    rbcs_pkg::pos_t   lo_reg;
    rbcs_pkg::pos_t   hi_reg;
    logic [1:0]       k_reg;
    logic             have3_reg;
    logic             have_any_reg;
    rbcs_pkg::word_t  p0c_reg;
    rbcs_pkg::word_t  r0_reg;
    rbcs_pkg::pos_t   s1_reg;
    rbcs_pkg::count_t count_reg;
    rbcs_pkg::word_t  p0_reg;
    rbcs_pkg::word_t  p1_reg;
    rbcs_pkg::word_t  p2_reg;
    rbcs_pkg::word_t  p3_reg;

    rbcs_pkg::pos_t    s0;
    rbcs_pkg::word_t   m0;
    rbcs_pkg::word_t   r0;
    rbcs_pkg::search_t srch1;
    rbcs_pkg::word_t   m1;
    rbcs_pkg::word_t   r1;
    rbcs_pkg::search_t srch2;
    rbcs_pkg::word_t   m2;
    rbcs_pkg::word_t   r2;

    always_comb
    begin
        s0    = lo_reg + {3'b000, k_reg, 1'b0};
        m0    = rbcs_pkg::rot_byte(s0);
        r0    = c_reg & ~m0;
        srch1 = rbcs_pkg::first_pair(r0, s0 + rbcs_pkg::pos_t'(8), hi_reg);
        m1    = rbcs_pkg::rot_byte(s1_reg);
        r1    = r0_reg & ~m1;
        srch2 = rbcs_pkg::first_pair(r1, s1_reg + rbcs_pkg::pos_t'(8), hi_reg);
        m2    = rbcs_pkg::rot_byte(srch2.pos);
        r2    = r1 & ~m2;
    end

    assign status.hit1   = (c_reg == '0) || (r0 == '0);
    assign status.skip1  = !srch1.found;
    assign status.hit2   = (r1 == '0);
    assign status.last_k = (k_reg == 2'd3);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_reg        <= constant_value;
            lo_reg       <= rbcs_pkg::low_pair(constant_value);
            hi_reg       <= rbcs_pkg::high_bound(constant_value);
            k_reg        <= 2'd0;
            have3_reg    <= 1'b0;
            have_any_reg <= 1'b0;
            count_reg    <= rbcs_pkg::CountFour;
            p0_reg       <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            p3_reg       <= '0;
        end
        else
        begin
            if (cmd.advance)
                k_reg <= k_reg + 2'd1;
            if (cmd.step1)
            begin
                if (c_reg == '0)
                begin
                    count_reg <= rbcs_pkg::CountOne;
                end
                else if (r0 == '0)
                begin
                    p0_reg    <= c_reg & m0;
                    p1_reg    <= '0;
                    p2_reg    <= '0;
                    p3_reg    <= '0;
                    count_reg <= rbcs_pkg::CountOne;
                end
                else
                begin
                    p0c_reg <= c_reg & m0;
                    r0_reg  <= r0;
                    s1_reg  <= srch1.pos;
                end
            end
            if (cmd.step2)
            begin
                if (r1 == '0)
                begin
                    p0_reg    <= p0c_reg;
                    p1_reg    <= r0_reg & m1;
                    p2_reg    <= '0;
                    p3_reg    <= '0;
                    count_reg <= rbcs_pkg::CountTwo;
                end
                else if (srch2.found)
                begin
                    if (r2 == '0 && !have3_reg)
                    begin
                        p0_reg       <= p0c_reg;
                        p1_reg       <= r0_reg & m1;
                        p2_reg       <= r1 & m2;
                        p3_reg       <= '0;
                        count_reg    <= rbcs_pkg::CountThree;
                        have3_reg    <= 1'b1;
                        have_any_reg <= 1'b1;
                    end
                    else if (!have_any_reg)
                    begin
                        p0_reg       <= p0c_reg;
                        p1_reg       <= r0_reg & m1;
                        p2_reg       <= r1 & m2;
                        p3_reg       <= r2;
                        count_reg    <= rbcs_pkg::CountFour;
                        have_any_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign piece_count = count_reg;
    assign piece_zero  = p0_reg;
    assign piece_one   = p1_reg;
    assign piece_two   = p2_reg;
    assign piece_three = p3_reg;

endmodule

// ===== rtl/rotated_byte_constant_splitter.sv =====
// Top level of the rotated byte constant splitter.
//
// A request is taken at a rising edge with start high and busy low; the
// constant rides on constant_value. The block splits it into the fewest
// pieces, each an 8-bit field rotated by an even amount, that OR back to
// the constant, and reports piece_count and piece_zero..piece_three.
// Unused pieces read as zero.
// busy is high from the edge at which a request is taken until the result
// has been shown. The result appears for exactly one cycle with done high
// and is taken at the edge that ends that cycle; the receiver cannot stall.
// The controller tries up to four starting rotations, each in ST_FIRST
// (first greedy piece) and, if needed, ST_SECOND (second and third).
// No new request is taken while busy; the next one is taken in the cycle
// after done at the earliest.
// Reset (rst_n low, asynchronous) returns the controller to idle; any item
// in progress is dropped and no result is shown for it.
module rotated_byte_constant_splitter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rbcs_pkg::word_t        constant_value,
    output logic                   done,
    output rbcs_pkg::count_t       piece_count,
    output rbcs_pkg::word_t        piece_zero,
    output rbcs_pkg::word_t        piece_one,
    output rbcs_pkg::word_t        piece_two,
    output rbcs_pkg::word_t        piece_three
);

    rbcs_pkg::cmd_t    cmd;
    rbcs_pkg::status_t status;

    rbcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rbcs_datapath u_datapath (
        .clk            (clk),
        .constant_value (constant_value),
        .cmd            (cmd),
        .status         (status),
        .piece_count    (piece_count),
        .piece_zero     (piece_zero),
        .piece_one      (piece_one),
        .piece_two      (piece_two),
        .piece_three    (piece_three)
    );

endmodule
